// ----- design/rtfsq_pkg.sv -----
`default_nettype none
package rtfsq_pkg;

   localparam int SLOTS   = 8;
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int CNT_W   = $clog2(SLOTS + 1);
   localparam int SUM_W   = CNT_W + 1;
   localparam int TIME_W  = 32;
   localparam int LIMIT_W = TIME_W + 1;
   localparam int FIELD_SLOT_W = 3;
   localparam int ENTRY_W = SLOT_W + TIME_W;

   localparam logic [TIME_W-1:0] DELAY_RESET = 32'd10;

   localparam logic CMD_ADD    = 1'b0;
   localparam logic CMD_SELECT = 1'b1;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_NONE = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD_WRITE,
      S_SEL_HEAD,
      S_SEL_NEXT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic              command;
      logic [TIME_W-1:0] frame_render_time;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic [FIELD_SLOT_W-1:0] slot;
      logic [TIME_W-1:0]       shown_render_time;
   } rsp_type;

   function automatic logic [SLOT_W-1:0] wrap_add(input logic [SLOT_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(off);
      if (sum >= SUM_W'(SLOTS)) begin
         sum = sum - SUM_W'(SLOTS);
      end
      return sum[SLOT_W-1:0];
   endfunction

   function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] base);
      return wrap_add(base, CNT_W'(1));
   endfunction

endpackage
`default_nettype wire

// ----- design/rtfsq_ram.sv -----
`default_nettype none
module rtfsq_ram #(
   parameter int DEPTH = 8,
   parameter int WIDTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- design/rtfsq_seq.sv -----
`default_nettype none
module rtfsq_seq
   import rtfsq_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire req_type           req,
   input  wire logic [TIME_W-1:0] delay,
   output logic                   res_valid,
   input  wire logic              res_ready,
   output rsp_type                res
);

   state_type state_ff, state_in;

   logic [SLOT_W-1:0]  q_head_ff, q_head_in;
   logic [CNT_W-1:0]   q_count_ff, q_count_in;
   logic [SLOT_W-1:0]  f_head_ff, f_head_in;
   logic [CNT_W-1:0]   f_count_ff, f_count_in;
   logic [SLOTS-1:0]   f_written_ff, f_written_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [TIME_W-1:0]  time_ff, time_in;
   logic [SLOT_W-1:0]  cur_slot_ff, cur_slot_in;
   logic [TIME_W-1:0]  cur_time_ff, cur_time_in;
   rsp_type            res_ff, res_in;

   logic               q_we;
   logic [SLOT_W-1:0]  q_waddr, q_raddr;
   logic [ENTRY_W-1:0] q_wdata, q_rdata;
   logic               f_we;
   logic [SLOT_W-1:0]  f_waddr, f_raddr;
   logic [SLOT_W-1:0]  f_wdata, f_rdata;

   logic [SLOT_W-1:0]  rd_slot;
   logic [TIME_W-1:0]  rd_time;
   logic               entry_ready;
   logic               accept;
   logic               pool_full;
   logic [SLOT_W-1:0]  new_slot;
   logic [SLOT_W-1:0]  next_head;

   rtfsq_ram #(.DEPTH(SLOTS), .WIDTH(ENTRY_W)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_addr (q_raddr),
      .rd_data (q_rdata)
   );

   rtfsq_ram #(.DEPTH(SLOTS), .WIDTH(SLOT_W)) u_free_ram (
      .clock   (clock),
      .wr_en   (f_we),
      .wr_addr (f_waddr),
      .wr_data (f_wdata),
      .rd_addr (f_raddr),
      .rd_data (f_rdata)
   );

   assign rd_slot     = q_rdata[SLOT_W-1:0];
   assign rd_time     = q_rdata[ENTRY_W-1:SLOT_W];
   assign entry_ready = ({1'b0, rd_time} <= limit_ff);
   assign accept      = req_valid && (state_ff == S_IDLE);
   assign pool_full   = (f_count_ff == '0) || (q_count_ff >= CNT_W'(SLOTS));
   assign new_slot    = f_written_ff[f_head_ff] ? f_rdata : f_head_ff;
   assign next_head   = wrap_inc(q_head_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req.command == CMD_ADD) begin
                  state_in = pool_full ? S_DONE : S_ADD_WRITE;
               end else begin
                  state_in = (q_count_ff == '0) ? S_DONE : S_SEL_HEAD;
               end
            end
         end
         S_ADD_WRITE: state_in = S_DONE;
         S_SEL_HEAD: begin
            if (entry_ready && q_count_ff >= CNT_W'(2)) begin
               state_in = S_SEL_NEXT;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SEL_NEXT: begin
            if (!(entry_ready && q_count_ff >= CNT_W'(3))) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      q_head_in    = q_head_ff;
      q_count_in   = q_count_ff;
      f_head_in    = f_head_ff;
      f_count_in   = f_count_ff;
      f_written_in = f_written_ff;
      limit_in     = limit_ff;
      time_in      = time_ff;
      cur_slot_in  = cur_slot_ff;
      cur_time_in  = cur_time_ff;
      res_in       = res_ff;
      q_we         = 1'b0;
      q_waddr      = wrap_add(q_head_ff, q_count_ff);
      q_wdata      = {time_ff, new_slot};
      q_raddr      = q_head_ff;
      f_we         = 1'b0;
      f_waddr      = wrap_add(f_head_ff, f_count_ff);
      f_wdata      = cur_slot_ff;
      f_raddr      = f_head_ff;
      req_ready    = 1'b0;
      res_valid    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               limit_in = {1'b0, req.now_ms} + {1'b0, delay};
               time_in  = req.frame_render_time;
               res_in   = '0;
               if (req.command == CMD_ADD) begin
                  if (pool_full) begin
                     res_in.status = STATUS_FULL;
                  end
               end else if (q_count_ff == '0) begin
                  res_in.status = STATUS_NONE;
               end
            end
         end
         S_ADD_WRITE: begin
            q_we                   = 1'b1;
            f_head_in              = wrap_inc(f_head_ff);
            f_count_in             = f_count_ff - CNT_W'(1);
            q_count_in             = q_count_ff + CNT_W'(1);
            res_in.status          = STATUS_OK;
            res_in.slot            = FIELD_SLOT_W'(new_slot);
            res_in.shown_render_time = '0;
         end
         S_SEL_HEAD: begin
            cur_slot_in = rd_slot;
            cur_time_in = rd_time;
            q_raddr     = next_head;
            if (!entry_ready) begin
               res_in.status = STATUS_NONE;
            end else begin
               res_in.status            = STATUS_OK;
               res_in.slot              = FIELD_SLOT_W'(rd_slot);
               res_in.shown_render_time = rd_time;
            end
         end
         S_SEL_NEXT: begin
            if (entry_ready) begin
               if (f_count_ff < CNT_W'(SLOTS)) begin
                  f_we                  = 1'b1;
                  f_written_in[f_waddr] = 1'b1;
                  f_count_in            = f_count_ff + CNT_W'(1);
               end
               q_head_in                = next_head;
               q_count_in               = q_count_ff - CNT_W'(1);
               q_raddr                  = wrap_inc(next_head);
               cur_slot_in              = rd_slot;
               cur_time_in              = rd_time;
               res_in.slot              = FIELD_SLOT_W'(rd_slot);
               res_in.shown_render_time = rd_time;
            end
         end
         S_DONE: begin
            res_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         q_head_ff    <= '0;
         q_count_ff   <= '0;
         f_head_ff    <= '0;
         f_count_ff   <= CNT_W'(SLOTS);
         f_written_ff <= '0;
      end else begin
         state_ff     <= state_in;
         q_head_ff    <= q_head_in;
         q_count_ff   <= q_count_in;
         f_head_ff    <= f_head_in;
         f_count_ff   <= f_count_in;
         f_written_ff <= f_written_in;
      end
   end

   always_ff @(posedge clock) begin
      limit_ff    <= limit_in;
      time_ff     <= time_in;
      cur_slot_ff <= cur_slot_in;
      cur_time_ff <= cur_time_in;
      res_ff      <= res_in;
   end

   assign res = res_ff;

endmodule
`default_nettype wire

// ----- design/render_time_frame_slot_queue_core.sv -----
// Request handling: an add goes through S_ADD_WRITE to S_DONE, a refused add straight
// to S_DONE; a select on an empty queue goes straight to S_DONE, else through S_SEL_HEAD
// and, while ready entries follow, S_SEL_NEXT, one queued entry per cycle through the
// shared time compare, read from the queue memory. One request is in flight at a
// time: the next is taken in the cycle after the result enters the output register.
// Reset (synchronous, active high): queue empty, free FIFO holds slots 0 to SLOTS-1
// in order, render delay 10 ms.
`default_nettype none
module render_time_frame_slot_queue_core
   import rtfsq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,  // frame_render_time[31:0], now_ms[63:32]
   input  wire logic        req_tuser,  // command[0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,  // slot[2:0], shown_render_time[34:3], zero[39:35]
   output logic [1:0]       rsp_tuser,  // status[1:0]
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data
);

   logic [TIME_W-1:0] delay_ff;
   logic              out_valid_ff;
   rsp_type           out_ff;
   req_type           req;
   rsp_type           res;
   logic              res_valid;
   logic              res_ready;

   assign req.command           = req_tuser;
   assign req.frame_render_time = req_tdata[31:0];
   assign req.now_ms            = req_tdata[63:32];

   assign res_ready = !out_valid_ff || rsp_tready;

   rtfsq_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .delay     (delay_ff),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff     <= DELAY_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            delay_ff <= csr_wr_data;
         end
         if (res_valid && res_ready) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         out_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.status;
   assign rsp_tdata  = {5'd0, out_ff.shown_render_time, out_ff.slot};

endmodule
`default_nettype wire

// ----- verif/render_time_frame_slot_queue_core_test.sv -----
`timescale 1ns / 100ps

module render_time_frame_slot_queue_core_test;
   import rtfsq_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 300;
   localparam int PHASE_ITEMS    = 95;

   class frame_slot_board;
      logic [TIME_W-1:0] delay_ms;
      logic [SLOT_W-1:0] queued_slot [SLOTS];
      logic [TIME_W-1:0] queued_time [SLOTS];
      logic [SLOT_W-1:0] queue_head;
      logic [CNT_W-1:0]  queue_count;
      logic [SLOT_W-1:0] free_slot [SLOTS];
      logic [SLOT_W-1:0] free_head;
      logic [CNT_W-1:0]  free_count;
      rsp_type           expected_rsp [$];
      int                failures;

      function new();
         delay_ms    = DELAY_RESET;
         queue_head  = '0;
         queue_count = '0;
         free_head   = '0;
         free_count  = CNT_W'(SLOTS);
         failures    = 0;
         for (int i = 0; i < SLOTS; i++) begin
            free_slot[i] = SLOT_W'(i);
         end
      endfunction

      function logic [SLOT_W-1:0] ring_index(input logic [SLOT_W-1:0] base,
                                             input logic [CNT_W-1:0] off);
         return SLOT_W'((int'(base) + int'(off)) % SLOTS);
      endfunction

      function void set_delay(input logic [TIME_W-1:0] value);
         delay_ms = value;
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction

      function void note_request(input logic cmd, input logic [TIME_W-1:0] frame_time,
                                 input logic [TIME_W-1:0] now);
         rsp_type            want;
         logic [LIMIT_W-1:0] limit;
         logic [SLOT_W-1:0]  tail;
         want = '0;
         want.status = STATUS_OK;
         if (cmd == CMD_ADD) begin
            if (free_count == 0 || queue_count >= SLOTS) begin
               want.status = STATUS_FULL;
            end else begin
               tail = ring_index(queue_head, queue_count);
               want.slot = FIELD_SLOT_W'(free_slot[free_head]);
               free_head = ring_index(free_head, CNT_W'(1));
               free_count--;
               queued_slot[tail] = want.slot;
               queued_time[tail] = frame_time;
               queue_count++;
            end
         end else begin
            limit = LIMIT_W'(now) + LIMIT_W'(delay_ms);
            if (queue_count == 0 || LIMIT_W'(queued_time[queue_head]) > limit) begin
               want.status = STATUS_NONE;
            end else begin
               // drop every ready entry but the newest
               while (queue_count >= 2 &&
                      LIMIT_W'(queued_time[ring_index(queue_head, CNT_W'(1))]) <= limit) begin
                  if (free_count < SLOTS) begin
                     free_slot[ring_index(free_head, free_count)] = queued_slot[queue_head];
                     free_count++;
                  end
                  queue_head = ring_index(queue_head, CNT_W'(1));
                  queue_count--;
               end
               want.slot = FIELD_SLOT_W'(queued_slot[queue_head]);
               want.shown_render_time = queued_time[queue_head];
            end
         end
         expected_rsp.push_back(want);
      endfunction

      function void check_response(input logic [1:0] status,
                                   input logic [FIELD_SLOT_W-1:0] slot,
                                   input logic [TIME_W-1:0] shown);
         rsp_type want;
         if (expected_rsp.size() == 0) begin
            $error("unexpected response: status %0d slot %0d shown_render_time %0h",
                   status, slot, shown);
            failures++;
            return;
         end
         want = expected_rsp.pop_front();
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            failures++;
         end
         if (slot !== want.slot) begin
            $error("slot: expected %0d, actual %0d", want.slot, slot);
            failures++;
         end
         if (shown !== want.shown_render_time) begin
            $error("shown_render_time: expected %0h, actual %0h",
                   want.shown_render_time, shown);
            failures++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // frame_render_time[31:0], now_ms[63:32]
   logic        req_tuser = 1'b0; // command[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // slot[2:0], shown_render_time[34:3], zero[39:35]
   logic [1:0]  rsp_tuser;        // status[1:0]
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;

   frame_slot_board   board = new();
   bit                sender_idles = 1'b1;
   bit                receiver_idles = 1'b1;
   bit                long_hold_asked = 1'b0;
   logic [TIME_W-1:0] stamp_ms;
   int                idle_cycles = 0;

   render_time_frame_slot_queue_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_response(rsp_tuser, rsp_tdata[2:0], rsp_tdata[34:3]);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (long_hold_asked) begin
            long_hold_asked = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_request(input logic cmd, input logic [TIME_W-1:0] frame_time,
                               input logic [TIME_W-1:0] now);
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {now, frame_time};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(cmd, frame_time, now);
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic write_delay(input logic [TIME_W-1:0] value);
      wait_for_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.set_delay(value);
   endtask

   task automatic run_random_items(input int count);
      logic              cmd;
      logic [TIME_W-1:0] frame_time;
      logic [TIME_W-1:0] now;
      repeat (count) begin
         stamp_ms = stamp_ms + TIME_W'($urandom_range(0, 20));
         cmd = ($urandom_range(0, 99) < 55) ? CMD_ADD : CMD_SELECT;
         if ($urandom_range(0, 9) == 0) begin
            frame_time = $urandom;
            now        = $urandom;
         end else begin
            // keep frame times and the ready limit close to one another
            frame_time = stamp_ms + TIME_W'($urandom_range(0, 40));
            now        = stamp_ms - board.delay_ms + TIME_W'($urandom_range(0, 40));
         end
         send_request(cmd, frame_time, now);
      end
   endtask

   initial begin
      stamp_ms = $urandom;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_request(CMD_SELECT, 32'd0, 32'd0);
      send_request(CMD_ADD, 32'd0, 32'd0);
      send_request(CMD_ADD, 32'hFFFF_FFFF, 32'd0);
      send_request(CMD_SELECT, 32'd0, 32'd0);
      send_request(CMD_SELECT, 32'd0, 32'hFFFF_FFFF);
      for (int i = 0; i < SLOTS; i++) begin
         send_request(CMD_ADD, 32'd100 + i, 32'hFFFF_FFFF);
      end
      send_request(CMD_SELECT, 32'hFFFF_FFFF, 32'd50);
      send_request(CMD_SELECT, 32'd0, 32'hFFFF_FFF0);
      send_request(CMD_SELECT, 32'd0, 32'hFFFF_FFF5);

      write_delay(32'd0);
      send_request(CMD_SELECT, 32'd0, 32'd106);
      send_request(CMD_SELECT, 32'd0, 32'd105);
      send_request(CMD_ADD, 32'd200, 32'd0);
      send_request(CMD_SELECT, 32'd0, 32'd199);

      write_delay(32'hFFFF_FFFF);
      send_request(CMD_ADD, 32'hFFFF_FFFF, 32'd0);
      send_request(CMD_SELECT, 32'd0, 32'hFFFF_FFFF);
      send_request(CMD_SELECT, 32'd0, 32'd0);
      run_random_items(PHASE_ITEMS / 2);

      write_delay(TIME_W'($urandom_range(1, 60)));
      long_hold_asked = 1'b1;
      run_random_items(PHASE_ITEMS);

      write_delay(32'd0);
      run_random_items(PHASE_ITEMS);

      write_delay($urandom);
      run_random_items(PHASE_ITEMS / 2);

      write_delay(DELAY_RESET);
      run_random_items(PHASE_ITEMS);

      // final stretch runs at full rate on both sides
      write_delay(TIME_W'($urandom_range(0, 30)));
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      run_random_items(PHASE_ITEMS);

      wait_for_results();
      repeat (SLOTS + 4) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/rtfsq_pkg.sv
design/rtfsq_ram.sv
design/rtfsq_seq.sv
design/render_time_frame_slot_queue_core.sv
verif/render_time_frame_slot_queue_core_test.sv
